// ===== rtl/anfc_pkg.sv =====
// Package for the ACK/NACK frame checker: frame layout, register indexes
// and the status codes. No dependencies.
package anfc_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;

  localparam logic [POS_W-1:0] POS_SYNC0 = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SYNC1 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LENHI = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LENLO = POS_W'(3);
  localparam logic [POS_W-1:0] POS_MSGID = POS_W'(4);
  localparam logic [POS_W-1:0] POS_BODY  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_CSUM  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);

  localparam logic [15:0] PAYLOAD_LEN = 16'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_ACK_CODE    = 2'd2,
    CFG_NACK_CODE   = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] RST_SYNC_FIRST  = 8'd160;
  localparam logic [7:0] RST_SYNC_SECOND = 8'd161;
  localparam logic [7:0] RST_ACK_CODE    = 8'd131;
  localparam logic [7:0] RST_NACK_CODE   = 8'd132;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_ACK          = 3'd0,
    ST_NACK         = 3'd1,
    ST_BAD_SYNC     = 3'd2,
    ST_BAD_LENGTH   = 3'd3,
    ST_BAD_CHECKSUM = 3'd4,
    ST_UNEXPECTED   = 3'd5
  } status_t;

endpackage

// ===== rtl/ack_nack_frame_checker.sv =====
// ACK/NACK frame checker: parses 9-byte response frames and reports a status.
// Depends on anfc_pkg.
//
// The status word is registered and appears in the cycle after the last byte of a frame.
// Throughput: one byte per cycle; the only stage is the output register, which
// keeps taking bytes while it is empty or being emptied in the same cycle.
// Reset (rst_n low, synchronous): frame position and flags cleared, output
// empty, configuration registers back to their default codes.
module ack_nack_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  // received bytes
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  // frame status
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] frame_status, [7:3] zero
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] sync_first_r, sync_second_r, ack_code_r, nack_code_r;

  logic [anfc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic        sync_fail_r, sync_fail_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  msg_id_r, msg_id_nxt;
  logic        csum_fail_r, csum_fail_nxt;

  logic                out_valid_r, out_valid_nxt;
  anfc_pkg::status_t   status_r, status_nxt, verdict;

  logic in_acc;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, status_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= anfc_pkg::RST_SYNC_FIRST;
      sync_second_r <= anfc_pkg::RST_SYNC_SECOND;
      ack_code_r    <= anfc_pkg::RST_ACK_CODE;
      nack_code_r   <= anfc_pkg::RST_NACK_CODE;
    end else if (cfg_valid) begin
      case (anfc_pkg::cfg_idx_t'(cfg_index))
        anfc_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        anfc_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_data;
        anfc_pkg::CFG_ACK_CODE:    ack_code_r    <= cfg_data;
        anfc_pkg::CFG_NACK_CODE:   nack_code_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // verdict from the flags gathered over bytes 0..6, in priority order
  always_comb begin
    if (sync_fail_r)                         verdict = anfc_pkg::ST_BAD_SYNC;
    else if (length_r != anfc_pkg::PAYLOAD_LEN) verdict = anfc_pkg::ST_BAD_LENGTH;
    else if (csum_fail_r)                    verdict = anfc_pkg::ST_BAD_CHECKSUM;
    else if (msg_id_r == ack_code_r)         verdict = anfc_pkg::ST_ACK;
    else if (msg_id_r == nack_code_r)        verdict = anfc_pkg::ST_NACK;
    else                                     verdict = anfc_pkg::ST_UNEXPECTED;
  end

  // per-byte parse and output register update
  always_comb begin
    pos_nxt       = pos_r;
    sync_fail_nxt = sync_fail_r;
    length_nxt    = length_r;
    xor_nxt       = xor_r;
    msg_id_nxt    = msg_id_r;
    csum_fail_nxt = csum_fail_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (in_acc) begin
      if (pos_r >= anfc_pkg::POS_LAST) begin
        // last byte (or an out-of-range position): emit status, restart
        status_nxt    = verdict;
        out_valid_nxt = 1'b1;
        pos_nxt       = anfc_pkg::POS_SYNC0;
      end else begin
        case (pos_r)
          anfc_pkg::POS_SYNC0: sync_fail_nxt = (in_tdata != sync_first_r);
          anfc_pkg::POS_SYNC1: begin
            if (in_tdata != sync_second_r) sync_fail_nxt = 1'b1;
          end
          anfc_pkg::POS_LENHI: length_nxt = {in_tdata, 8'h00};
          anfc_pkg::POS_LENLO: length_nxt = {length_r[15:8], in_tdata};
          anfc_pkg::POS_MSGID: begin
            msg_id_nxt = in_tdata;
            xor_nxt    = in_tdata;
          end
          anfc_pkg::POS_BODY:  xor_nxt = xor_r ^ in_tdata;
          anfc_pkg::POS_CSUM:  csum_fail_nxt = (in_tdata != xor_r);
          default: ;
        endcase
        pos_nxt = pos_r + anfc_pkg::POS_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sync_fail_r <= 1'b0;
      length_r    <= '0;
      xor_r       <= '0;
      msg_id_r    <= '0;
      csum_fail_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sync_fail_r <= sync_fail_nxt;
      length_r    <= length_nxt;
      xor_r       <= xor_nxt;
      msg_id_r    <= msg_id_nxt;
      csum_fail_r <= csum_fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // status payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

endmodule

// ===== rtl/anfc_checker.sv =====
// Port-level checks for the ACK/NACK frame checker, bound to its top level.
// Depends on the ports of ack_nack_frame_checker only.
module anfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a held status word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("status word changed while stalled");

  // status codes stay in the defined range, upper bits zero
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:3] == 5'd0 && out_tdata[2:0] <= 3'd5)
    else $error("status word out of range");

  // a new status word needs a byte taken in the cycle before
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("status word without an input byte");

  // output empties on reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input is never blocked while the output is empty
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind ack_nack_frame_checker anfc_checker u_anfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/tb_ack_nack_frame_checker.sv =====
// Self-checking testbench for ack_nack_frame_checker: streams 9-byte response
// frames, predicts every frame status in a small scoreboard and checks each word.
// Depends on anfc_pkg and the ack_nack_frame_checker RTL.
`timescale 1ns / 1ps

// Shadow of the checker: registers, frame state and the statuses still owed
class frame_tracker_t;
  logic [7:0]                 sync_first_r;
  logic [7:0]                 sync_second_r;
  logic [7:0]                 ack_code_r;
  logic [7:0]                 nack_code_r;
  logic [anfc_pkg::POS_W-1:0] pos;
  bit                         sync_bad;
  bit                         csum_bad;
  logic [15:0]                len_word;
  logic [7:0]                 xor_acc;
  logic [7:0]                 msg_id;
  anfc_pkg::status_t          status_due[$];
  int                         errors;

  function new();
    sync_first_r  = anfc_pkg::RST_SYNC_FIRST;
    sync_second_r = anfc_pkg::RST_SYNC_SECOND;
    ack_code_r    = anfc_pkg::RST_ACK_CODE;
    nack_code_r   = anfc_pkg::RST_NACK_CODE;
    pos           = '0;
    sync_bad      = 1'b0;
    csum_bad      = 1'b0;
    len_word      = '0;
    xor_acc       = '0;
    msg_id        = '0;
    errors        = 0;
  endfunction

  function void set_reg(anfc_pkg::cfg_idx_t idx, logic [7:0] v);
    case (idx)
      anfc_pkg::CFG_SYNC_FIRST:  sync_first_r  = v;
      anfc_pkg::CFG_SYNC_SECOND: sync_second_r = v;
      anfc_pkg::CFG_ACK_CODE:    ack_code_r    = v;
      anfc_pkg::CFG_NACK_CODE:   nack_code_r   = v;
      default: ;
    endcase
  endfunction

  // Checks in priority order; equal ack and nack codes resolve to ack
  function anfc_pkg::status_t judge_frame();
    if (sync_bad) return anfc_pkg::ST_BAD_SYNC;
    if (len_word != anfc_pkg::PAYLOAD_LEN) return anfc_pkg::ST_BAD_LENGTH;
    if (csum_bad) return anfc_pkg::ST_BAD_CHECKSUM;
    if (msg_id == ack_code_r) return anfc_pkg::ST_ACK;
    if (msg_id == nack_code_r) return anfc_pkg::ST_NACK;
    return anfc_pkg::ST_UNEXPECTED;
  endfunction

  // One accepted byte; the last position of the frame yields a status
  function void take_byte(logic [7:0] b);
    if (pos >= anfc_pkg::POS_LAST) begin
      status_due.push_back(judge_frame());
      pos = '0;
      return;
    end
    case (pos)
      anfc_pkg::POS_SYNC0: sync_bad = (b != sync_first_r);
      anfc_pkg::POS_SYNC1: if (b != sync_second_r) sync_bad = 1'b1;
      anfc_pkg::POS_LENHI: len_word = {b, 8'h00};
      anfc_pkg::POS_LENLO: len_word[7:0] = b;
      anfc_pkg::POS_MSGID: begin
        msg_id  = b;
        xor_acc = b;
      end
      anfc_pkg::POS_BODY:  xor_acc = xor_acc ^ b;
      anfc_pkg::POS_CSUM:  csum_bad = (b != xor_acc);
      default: ;
    endcase
    pos = pos + anfc_pkg::POS_W'(1);
  endfunction

  function void check_status(logic [7:0] word);
    anfc_pkg::status_t want;
    if (status_due.size() == 0) begin
      errors++;
      $display("%0t: status word with none pending, expected none actual %0d",
               $time, word);
      return;
    end
    want = status_due.pop_front();
    if (word !== {5'd0, want}) begin
      errors++;
      $display("%0t: frame status mismatch, expected %0d actual %0d", $time, want, word);
    end
  endfunction
endclass

module tb_ack_nack_frame_checker;

  localparam int QUIET_LIMIT = 2000;

  typedef enum int {
    FK_ACK, FK_NACK, FK_UNEXP, FK_SYNC, FK_LEN, FK_CSUM, FK_MULTI, FK_NOISE
  } frame_kind_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  frame_tracker_t sb;
  logic [7:0]     byte_q[$];
  bit             idle_en  = 1'b1;
  bit             stall_en = 1'b1;
  int             quiet_cycles = 0;

  ack_nack_frame_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: ready held in random stretches, broken by random stalls
  initial begin
    out_tready <= 1'b0;
    forever begin
      if (stall_en && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Status word check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL ack_nack_frame_checker");
      $finish;
    end
  end

  // Leaves cfg_valid high so back-to-back writes stay contiguous
  task automatic write_reg(input anfc_pkg::cfg_idx_t idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic load_codes(input logic [7:0] s0, input logic [7:0] s1,
                            input logic [7:0] ack, input logic [7:0] nack);
    write_reg(anfc_pkg::CFG_SYNC_FIRST, s0);
    write_reg(anfc_pkg::CFG_SYNC_SECOND, s1);
    write_reg(anfc_pkg::CFG_ACK_CODE, ack);
    write_reg(anfc_pkg::CFG_NACK_CODE, nack);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_byte(b);
  endtask

  // Drain: all statuses back, then let the output register settle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Builds one frame against the current codes, with the requested defects
  function automatic void queue_frame(frame_kind_t kind);
    logic [7:0]  s0;
    logic [7:0]  s1;
    logic [7:0]  id;
    logic [7:0]  body;
    logic [7:0]  csum;
    logic [15:0] len;
    int          which;
    s0   = sb.sync_first_r;
    s1   = sb.sync_second_r;
    len  = anfc_pkg::PAYLOAD_LEN;
    body = 8'($urandom);
    case (kind)
      FK_ACK:  id = sb.ack_code_r;
      FK_NACK: id = sb.nack_code_r;
      default: id = 8'($urandom);
    endcase
    if (kind == FK_UNEXP)
      while (id == sb.ack_code_r || id == sb.nack_code_r) id = 8'($urandom);
    csum = id ^ body;
    case (kind)
      FK_SYNC: begin
        which = $urandom_range(1, 3);
        if (which[0]) s0 = s0 ^ 8'($urandom_range(1, 255));
        if (which[1]) s1 = s1 ^ 8'($urandom_range(1, 255));
      end
      FK_LEN:  len  = len ^ 16'($urandom_range(1, 65535));
      FK_CSUM: csum = csum ^ 8'($urandom_range(1, 255));
      // several defects at once, to exercise the priority
      FK_MULTI: begin
        if ($urandom_range(0, 1)) s0 = s0 ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) s1 = s1 ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) len = len ^ 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 1)) csum = csum ^ 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    if (kind == FK_NOISE) begin
      repeat (anfc_pkg::FRAME_BYTES) byte_q.push_back(8'($urandom));
    end else begin
      byte_q.push_back(s0);
      byte_q.push_back(s1);
      byte_q.push_back(len[15:8]);
      byte_q.push_back(len[7:0]);
      byte_q.push_back(id);
      byte_q.push_back(body);
      byte_q.push_back(csum);
      byte_q.push_back(8'($urandom));
      byte_q.push_back(8'($urandom));
    end
  endfunction

  // Mostly well-formed frames, some defective, a little noise
  function automatic frame_kind_t pick_kind();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return FK_ACK;
      4, 5, 6:    return FK_NACK;
      7, 8:       return FK_UNEXP;
      9:          return FK_SYNC;
      10:         return FK_LEN;
      11:         return FK_CSUM;
      12, 13:     return FK_MULTI;
      14:         return FK_NOISE;
      default:    return FK_ACK;
    endcase
  endfunction

  // Sends a byte count that usually ends mid-frame; the rest carries over
  task automatic run_bytes(input int count);
    repeat (count) begin
      if (byte_q.size() == 0) queue_frame(pick_kind());
      send_byte(byte_q.pop_front());
    end
    settle();
  endtask

  initial begin
    logic [7:0] ack;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= anfc_pkg::CFG_SYNC_FIRST;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default codes, one frame per identifier outcome
    queue_frame(FK_ACK);
    queue_frame(FK_NACK);
    queue_frame(FK_UNEXP);
    run_bytes(27);

    // Extreme codes, then equal ack and nack codes
    load_codes(8'h00, 8'hFF, 8'hFF, 8'h00);
    run_bytes($urandom_range(90, 115));
    load_codes(8'hFF, 8'h00, 8'h00, 8'h00);
    run_bytes($urandom_range(90, 115));

    // Random codes, sometimes ack equal to nack, random idling per phase
    repeat (6) begin
      idle_en  = ($urandom_range(0, 3) != 0);
      stall_en = ($urandom_range(0, 3) != 0);
      ack = 8'($urandom);
      load_codes(8'($urandom), 8'($urandom), ack,
                 ($urandom_range(0, 3) == 0) ? ack : 8'($urandom));
      run_bytes($urandom_range(90, 115));
    end

    // Last part at full rate on both sides
    idle_en  = 1'b0;
    stall_en = 1'b0;
    load_codes(anfc_pkg::RST_SYNC_FIRST, anfc_pkg::RST_SYNC_SECOND,
               anfc_pkg::RST_ACK_CODE, anfc_pkg::RST_NACK_CODE);
    run_bytes($urandom_range(90, 115));

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.status_due.size() == 0)
      $display("PASS ack_nack_frame_checker");
    else
      $display("FAIL ack_nack_frame_checker");
    $finish;
  end

endmodule
